FILE: src/sfd_pkg.sv
// shared types and constants for the stereo feedback delay
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int DELAY_W    = 17;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_DELAY     = 3'd0,
    CFG_RIGHT_DELAY    = 3'd1,
    CFG_DELAY_LINK     = 3'd2,
    CFG_LEFT_FEEDBACK  = 3'd3,
    CFG_RIGHT_FEEDBACK = 3'd4,
    CFG_FEEDBACK_LINK  = 3'd5,
    CFG_WET_MIX        = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_ADDR  = 3'd1,
    OP_READ  = 3'd2,
    OP_MULX  = 3'd3,
    OP_MULD  = 3'd4,
    OP_ROUND = 3'd5,
    OP_MULFB = 3'd6,
    OP_WRITE = 3'd7
  } dp_op_e;

  typedef struct packed {
    logic   load;
    dp_op_e op;
    logic   ch;
    logic   adv;
    logic   out_load;
  } dp_cmd_t;

endpackage

FILE: src/sfd_if.sv
// stream interfaces for input and output sample frames
`timescale 1ns / 1ps

interface sfd_in_if import sfd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_in;
  logic signed [SAMPLE_W-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface sfd_out_if import sfd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

FILE: src/sfd_ctrl.sv
// sequencer that steps both channels of a frame through the shared datapath
`timescale 1ns / 1ps

module sfd_ctrl import sfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ADDR  = 9'b000000010,
    S_READ  = 9'b000000100,
    S_MULX  = 9'b000001000,
    S_MULD  = 9'b000010000,
    S_ROUND = 9'b000100000,
    S_MULFB = 9'b001000000,
    S_WRITE = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   ch_q, ch_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d          = state_q;
    ch_d             = ch_q;
    out_valid_d      = out_valid_q;
    cmd_o.load       = 1'b0;
    cmd_o.op         = OP_NONE;
    cmd_o.ch         = ch_q;
    cmd_o.adv        = 1'b0;
    cmd_o.out_load   = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          ch_d       = 1'b0;
          state_d    = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd_o.op = OP_ADDR;
        state_d  = S_READ;
      end
      S_READ: begin
        cmd_o.op = OP_READ;
        state_d  = S_MULX;
      end
      S_MULX: begin
        cmd_o.op = OP_MULX;
        state_d  = S_MULD;
      end
      S_MULD: begin
        cmd_o.op = OP_MULD;
        state_d  = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.op = OP_ROUND;
        state_d  = S_MULFB;
      end
      S_MULFB: begin
        cmd_o.op = OP_MULFB;
        state_d  = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.op = OP_WRITE;
        if (ch_q) begin
          cmd_o.adv = 1'b1;
          state_d   = S_OUT;
        end else begin
          ch_d    = 1'b1;
          state_d = S_ADDR;
        end
      end
      S_OUT: begin
        // wait until the output slot is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_starts_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_ADDR && !ch_q)
    else $error("accepted beat did not start the left channel");

  a_left_then_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WRITE && !ch_q |=> state_q == S_ADDR && ch_q)
    else $error("right channel did not follow the left channel");

  a_result_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result raised outside the output step");

  a_pending_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && out_valid_q && !out_ready_i |=> state_q == S_OUT)
    else $error("new result loaded over a pending beat");

endmodule

FILE: src/sfd_datapath.sv
// config registers, delay memories, shared multiplier and rounding for both channels
`timescale 1ns / 1ps

module sfd_datapath import sfd_pkg::*; #(
  parameter int DELAY_DEPTH = 131072
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  input  dp_cmd_t                    cmd_i,
  input  logic signed [SAMPLE_W-1:0] left_in_i,
  input  logic signed [SAMPLE_W-1:0] right_in_i,
  output logic signed [SAMPLE_W-1:0] left_out_o,
  output logic signed [SAMPLE_W-1:0] right_out_o
);

  localparam int PtrW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int CW   = (PtrW + 1 > DELAY_W) ? PtrW + 1 : DELAY_W;
  localparam int MulW = GAIN_W + 1 + SAMPLE_W;
  localparam int AccW = MulW + 1;
  localparam int RndW = AccW - 15;
  localparam int SumW = RndW + 1;
  localparam logic [GAIN_W-1:0] QOne = GAIN_W'(32768);

  // configuration
  logic [DELAY_W-1:0] left_delay_q, right_delay_q;
  logic               delay_link_q, feedback_link_q;
  logic [GAIN_W-1:0]  left_fb_q, right_fb_q, wet_mix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_delay_q    <= '0;
      right_delay_q   <= '0;
      delay_link_q    <= 1'b0;
      left_fb_q       <= '0;
      right_fb_q      <= '0;
      feedback_link_q <= 1'b0;
      wet_mix_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LEFT_DELAY:     left_delay_q    <= cfg_wdata_i[DELAY_W-1:0];
        CFG_RIGHT_DELAY:    right_delay_q   <= cfg_wdata_i[DELAY_W-1:0];
        CFG_DELAY_LINK:     delay_link_q    <= cfg_wdata_i[0];
        CFG_LEFT_FEEDBACK:  left_fb_q       <= cfg_wdata_i[GAIN_W-1:0];
        CFG_RIGHT_FEEDBACK: right_fb_q      <= cfg_wdata_i[GAIN_W-1:0];
        CFG_FEEDBACK_LINK:  feedback_link_q <= cfg_wdata_i[0];
        CFG_WET_MIX:        wet_mix_q       <= cfg_wdata_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective gains and delays
  logic [GAIN_W-1:0]  wet, dry, fb_l, fb_r, fb_ch;
  logic [DELAY_W-1:0] delay_raw;
  logic [CW-1:0]      delay_ext;
  logic [PtrW-1:0]    delay_ptr;

  assign wet   = (wet_mix_q > QOne) ? QOne : wet_mix_q;
  assign dry   = GAIN_W'({1'b0, QOne} - {1'b0, wet});
  assign fb_l  = (left_fb_q > QOne) ? QOne : left_fb_q;
  assign fb_r  = feedback_link_q ? fb_l : ((right_fb_q > QOne) ? QOne : right_fb_q);
  assign fb_ch = cmd_i.ch ? fb_r : fb_l;

  assign delay_raw = !cmd_i.ch ? left_delay_q : (delay_link_q ? left_delay_q : right_delay_q);
  assign delay_ext = CW'(delay_raw);
  assign delay_ptr = (delay_ext >= CW'(DELAY_DEPTH)) ? PtrW'(DELAY_DEPTH - 1)
                                                     : delay_ext[PtrW-1:0];

  // write pointer and fill tracking: entries below the pointer or all once wrapped
  logic [PtrW-1:0] wptr_q;
  logic            full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      full_q <= 1'b0;
    end else if (cmd_i.adv) begin
      if (wptr_q == PtrW'(DELAY_DEPTH - 1)) begin
        wptr_q <= '0;
        full_q <= 1'b1;
      end else begin
        wptr_q <= wptr_q + 1'b1;
      end
    end
  end

  logic [PtrW:0]   wrap_sum;
  logic [PtrW-1:0] rd_addr_d;

  assign wrap_sum  = {1'b0, wptr_q} + (PtrW + 1)'(DELAY_DEPTH) - {1'b0, delay_ptr};
  assign rd_addr_d = (wptr_q >= delay_ptr) ? (wptr_q - delay_ptr) : wrap_sum[PtrW-1:0];

  // sample registers
  logic signed [SAMPLE_W-1:0] x0_q, x1_q, x_ch;
  logic signed [SAMPLE_W-1:0] y0_q, y1_q, y_ch;
  logic signed [SAMPLE_W-1:0] left_out_q, right_out_q;
  logic [PtrW-1:0]            rd_addr_q;
  logic                       zero_delay_q, rd_valid_q;
  logic signed [SAMPLE_W-1:0] mem0_rd_q, mem1_rd_q, delayed;
  logic signed [AccW-1:0]     acc_q;

  assign x_ch = cmd_i.ch ? x1_q : x0_q;
  assign y_ch = cmd_i.ch ? y1_q : y0_q;

  always_comb begin
    if (zero_delay_q) begin
      delayed = x_ch;
    end else if (!rd_valid_q) begin
      delayed = '0;
    end else begin
      delayed = cmd_i.ch ? mem1_rd_q : mem0_rd_q;
    end
  end

  // shared multiplier
  logic [GAIN_W-1:0]          mul_gain;
  logic signed [SAMPLE_W-1:0] mul_smp;
  logic signed [MulW-1:0]     mul_p;

  always_comb begin
    case (cmd_i.op)
      OP_MULX: begin
        mul_gain = dry;
        mul_smp  = x_ch;
      end
      OP_MULD: begin
        mul_gain = wet;
        mul_smp  = delayed;
      end
      OP_MULFB: begin
        mul_gain = fb_ch;
        mul_smp  = y_ch;
      end
      default: begin
        mul_gain = wet;
        mul_smp  = x_ch;
      end
    endcase
  end

  assign mul_p = $signed({1'b0, mul_gain}) * mul_smp;

  // round half up: add one half, then arithmetic shift by 15
  logic signed [AccW-1:0]     acc_rnd;
  logic signed [RndW-1:0]     rnd_v;
  logic signed [SumW-1:0]     entry_sum;
  logic signed [SAMPLE_W-1:0] y_sat, entry;

  function automatic logic signed [SAMPLE_W-1:0] sat_smp(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'({1'b0, {(SAMPLE_W - 1){1'b1}}});
    lo = -hi - SumW'(1);
    if (v > hi) begin
      sat_smp = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end else if (v < lo) begin
      sat_smp = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    end else begin
      sat_smp = v[SAMPLE_W-1:0];
    end
  endfunction

  assign acc_rnd   = acc_q + AccW'(16384);
  assign rnd_v     = acc_rnd[AccW-1:15];
  assign y_sat     = sat_smp({rnd_v[RndW-1], rnd_v});
  assign entry_sum = {{(SumW - SAMPLE_W){x_ch[SAMPLE_W-1]}}, x_ch}
                   + {rnd_v[RndW-1], rnd_v};
  assign entry     = sat_smp(entry_sum);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x0_q <= left_in_i;
      x1_q <= right_in_i;
    end
    case (cmd_i.op)
      OP_ADDR: begin
        rd_addr_q    <= rd_addr_d;
        zero_delay_q <= (delay_ptr == '0);
        rd_valid_q   <= full_q || (rd_addr_d < wptr_q);
      end
      OP_MULX:  acc_q <= {mul_p[MulW-1], mul_p};
      OP_MULD:  acc_q <= acc_q + {mul_p[MulW-1], mul_p};
      OP_MULFB: acc_q <= {mul_p[MulW-1], mul_p};
      OP_ROUND: begin
        if (cmd_i.ch) begin
          y1_q <= y_sat;
        end else begin
          y0_q <= y_sat;
        end
      end
      default: ;
    endcase
    if (cmd_i.out_load) begin
      left_out_q  <= y0_q;
      right_out_q <= y1_q;
    end
  end

  // delay lines, one per channel
  logic signed [SAMPLE_W-1:0] mem0 [DELAY_DEPTH];
  logic signed [SAMPLE_W-1:0] mem1 [DELAY_DEPTH];

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WRITE && !cmd_i.ch) begin
      mem0[wptr_q] <= entry;
    end
    if (cmd_i.op == OP_READ) begin
      mem0_rd_q <= mem0[rd_addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WRITE && cmd_i.ch) begin
      mem1[wptr_q] <= entry;
    end
    if (cmd_i.op == OP_READ) begin
      mem1_rd_q <= mem1[rd_addr_q];
    end
  end

  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

endmodule

FILE: src/stereo_feedback_delay_top.sv
// stereo feedback delay top: one frame at a time, the two channels in turn
// through one shared multiplier, seven steps per channel plus one output step
// the result beat is raised from the output step, once the previous beat has been taken
// the next input beat is taken while a finished result still waits on the output
// reset clears control and config; unwritten delay entries read as zero via fill tracking
`timescale 1ns / 1ps

module stereo_feedback_delay_top import sfd_pkg::*; #(
  parameter int DELAY_DEPTH = 131072
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  sfd_in_if.sink                in_i,
  sfd_out_if.source             out_o
);

  dp_cmd_t cmd;

  sfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  sfd_datapath #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .left_in_i   (in_i.left_in),
    .right_in_i  (in_i.right_in),
    .left_out_o  (out_o.left_out),
    .right_out_o (out_o.right_out)
  );

endmodule

FILE: tb/tb.sv
// testbench for the stereo feedback delay: directed and random frames checked against a predictor
`timescale 1ns / 1ps

module tb;
  import sfd_pkg::*;

  localparam int LINE_DEPTH     = 131072;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int IDLE_PCT       = 37;
  localparam int RANDOM_PHASES  = 9;
  localparam int PHASE_FRAMES   = 110;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } frame_t;

  typedef struct packed {
    logic [DELAY_W-1:0] left_delay;
    logic [DELAY_W-1:0] right_delay;
    logic               delay_link;
    logic [GAIN_W-1:0]  left_fb;
    logic [GAIN_W-1:0]  right_fb;
    logic               fb_link;
    logic [GAIN_W-1:0]  wet;
  } settings_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  cfg_idx_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sfd_in_if  in_bus ();
  sfd_out_if out_bus ();

  stereo_feedback_delay_top #(
    .DELAY_DEPTH (LINE_DEPTH)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: both delay lines, the shared pointer and the live settings
  shortint            echo_line [2][LINE_DEPTH];
  logic [DELAY_W-1:0] write_ptr = '0;
  settings_t          live_cfg = '0;

  frame_t mixed_frames_due[$];
  int     mismatches = 0;
  int     quiet_cycles = 0;
  bit     calm = 1'b0;

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // round half up: floor of (v + half) / one
  function automatic longint q15_round(longint v);
    return (v + 16384) >>> 15;
  endfunction

  function automatic logic [GAIN_W-1:0] gain_limit(logic [GAIN_W-1:0] g);
    return (g > 16'h8000) ? 16'h8000 : g;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] mix_channel(int ch,
      logic signed [SAMPLE_W-1:0] x, logic [DELAY_W-1:0] dly,
      logic [GAIN_W-1:0] fb, logic [GAIN_W-1:0] wet);
    longint             tap;
    longint             mixed;
    longint             stored;
    logic [DELAY_W-1:0] rd_ptr;
    rd_ptr = write_ptr - dly;
    tap    = (dly == '0) ? longint'(x) : longint'(echo_line[ch][rd_ptr]);
    mixed  = clip16(q15_round((longint'(32768) - longint'(wet)) * longint'(x)
                              + longint'(wet) * tap));
    stored = clip16(longint'(x) + q15_round(longint'(fb) * mixed));
    echo_line[ch][write_ptr] = shortint'(stored);
    return mixed[SAMPLE_W-1:0];
  endfunction

  function automatic frame_t echo_mix_frame(frame_t f);
    frame_t             y;
    logic [GAIN_W-1:0]  wet;
    logic [GAIN_W-1:0]  fb_l;
    logic [GAIN_W-1:0]  fb_r;
    logic [DELAY_W-1:0] dly_r;
    wet   = gain_limit(live_cfg.wet);
    fb_l  = gain_limit(live_cfg.left_fb);
    fb_r  = live_cfg.fb_link ? fb_l : gain_limit(live_cfg.right_fb);
    dly_r = live_cfg.delay_link ? live_cfg.left_delay : live_cfg.right_delay;
    y.left  = mix_channel(0, f.left, live_cfg.left_delay, fb_l, wet);
    y.right = mix_channel(1, f.right, dly_r, fb_r, wet);
    write_ptr = write_ptr + 1'b1;
    return y;
  endfunction

  task automatic report_mismatch(string what, logic [SAMPLE_W-1:0] got,
                                 logic [SAMPLE_W-1:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
             $signed(want), $time);
    mismatches++;
  endtask

  // sender: random gaps, valid held across back-to-back beats
  task automatic send_frame(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
    frame_t f;
    f.left  = l;
    f.right = r;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid    <= 1'b1;
    in_bus.left_in  <= l;
    in_bus.right_in <= r;
    do @(posedge clk_i); while (!in_bus.ready);
    mixed_frames_due.push_back(echo_mix_frame(f));
  endtask

  task automatic settle_results();
    in_bus.valid <= 1'b0;
    while (mixed_frames_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
  endtask

  // all seven registers, written only once the block has gone quiet
  task automatic load_settings(settings_t s);
    settle_results();
    put_reg(CFG_LEFT_DELAY, s.left_delay);
    put_reg(CFG_RIGHT_DELAY, s.right_delay);
    put_reg(CFG_DELAY_LINK, CFG_DATA_W'(s.delay_link));
    put_reg(CFG_LEFT_FEEDBACK, CFG_DATA_W'(s.left_fb));
    put_reg(CFG_RIGHT_FEEDBACK, CFG_DATA_W'(s.right_fb));
    put_reg(CFG_FEEDBACK_LINK, CFG_DATA_W'(s.fb_link));
    put_reg(CFG_WET_MIX, CFG_DATA_W'(s.wet));
    cfg_we   <= 1'b0;
    live_cfg = s;
  endtask

  function automatic logic [DELAY_W-1:0] pick_delay();
    case ($urandom_range(9))
      0:          return '0;
      1, 2, 3, 4: return DELAY_W'($urandom_range(1, 8));
      5, 6, 7:    return DELAY_W'($urandom_range(9, 300));
      8:          return DELAY_W'(LINE_DEPTH - 1);
      default:    return DELAY_W'($urandom_range(LINE_DEPTH - 1));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 16'h8000;
      2:       return GAIN_W'($urandom_range(32769, 65535));
      default: return GAIN_W'($urandom_range(32768));
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return SAMPLE_W'($urandom_range(16)) - 16'sd8;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic settings_t random_settings();
    settings_t s;
    s.left_delay  = pick_delay();
    s.right_delay = pick_delay();
    s.delay_link  = 1'($urandom_range(1));
    s.left_fb     = pick_gain();
    s.right_fb    = pick_gain();
    s.fb_link     = 1'($urandom_range(1));
    s.wet         = pick_gain();
    return s;
  endfunction

  // reset settings: dry only, so every beat passes straight through
  task automatic test_reset_passthrough();
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh8000, 16'sh7fff);
    send_frame(16'sh0000, -16'sd1);
  endtask

  // zero delay reads the current sample; full feedback doubles it into the line
  task automatic test_zero_delay();
    load_settings('{left_delay: 0, right_delay: 0, delay_link: 1'b0, left_fb: 16'h8000,
                    right_fb: 16'h8000, fb_link: 1'b0, wet: 16'h8000});
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh8000, 16'sh7fff);
    send_frame(16'sd1, -16'sd1);
  endtask

  // gains above one clamp to unity
  task automatic test_gain_clamp();
    load_settings('{left_delay: 1, right_delay: 2, delay_link: 1'b0, left_fb: 16'hffff,
                    right_fb: 16'h8001, fb_link: 1'b0, wet: 16'hffff});
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh8000, 16'sh7fff);
    send_frame(16'sd100, -16'sd100);
  endtask

  // half-way products land on exact halves
  task automatic test_rounding();
    load_settings('{left_delay: 1, right_delay: 1, delay_link: 1'b0, left_fb: 16'h4000,
                    right_fb: 16'h4000, fb_link: 1'b0, wet: 16'h4000});
    send_frame(-16'sd1, 16'sd1);
    send_frame(16'sd1, -16'sd3);
    send_frame(-16'sd3, 16'sd3);
    send_frame(16'sd0, 16'sd0);
  endtask

  // right channel follows the left delay and feedback
  task automatic test_links();
    load_settings('{left_delay: 1, right_delay: 3, delay_link: 1'b1, left_fb: 16'h6000,
                    right_fb: 16'h0000, fb_link: 1'b1, wet: 16'h5000});
    send_frame(16'sd20000, -16'sd20000);
    send_frame(-16'sd12345, 16'sd54);
    send_frame(16'sd777, 16'sd30000);
    send_frame(16'sd0, 16'sd0);
  endtask

  // deepest tap of the line, and a delay of one on the other side
  task automatic test_longest_delay();
    load_settings('{left_delay: DELAY_W'(LINE_DEPTH - 1), right_delay: 1, delay_link: 1'b0,
                    left_fb: 16'h8000, right_fb: 16'h7fff, fb_link: 1'b0, wet: 16'h8000});
    send_frame(16'sh7fff, 16'sh7fff);
    send_frame(16'sh8000, 16'sh8000);
    send_frame(16'sd5, -16'sd5);
  endtask

  task automatic test_random_frames();
    settings_t s;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      s = random_settings();
      // first phase rings hard so echoes pile up and clip
      if (ph == 0) s = '{left_delay: 3, right_delay: 5, delay_link: 1'b0,
                         left_fb: 16'h8000, right_fb: 16'h7000, fb_link: 1'b0,
                         wet: 16'h6000};
      load_settings(s);
      calm = (ph == 4);
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        // sender holds off until the output side has caught up
        if (ph == 6 && n == PHASE_FRAMES / 2) settle_results();
        send_frame(pick_sample(), pick_sample());
      end
      calm = 1'b0;
    end
  endtask

  // receiver: random stalls, each accepted beat checked against the oldest prediction
  always @(posedge clk_i) begin : result_check
    frame_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (out_bus.valid && out_bus.ready) begin
        if (mixed_frames_due.size() == 0) begin
          report_mismatch("unexpected beat left", out_bus.left_out, '0);
        end else begin
          want = mixed_frames_due.pop_front();
          if (out_bus.left_out !== want.left)
            report_mismatch("left_out", out_bus.left_out, want.left);
          if (out_bus.right_out !== want.right)
            report_mismatch("right_out", out_bus.right_out, want.right);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= CFG_LEFT_DELAY;
    cfg_wdata       <= '0;
    in_bus.valid    <= 1'b0;
    in_bus.left_in  <= '0;
    in_bus.right_in <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_passthrough();
    test_zero_delay();
    test_gain_clamp();
    test_rounding();
    test_links();
    test_longest_delay();
    test_random_frames();
    settle_results();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
